[rtl/core/rtc_pkg.sv]
package rtc_pkg;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_RTD_DIVISOR    = 3'd0;
	localparam logic [2:0] REG_BAT_DIVISOR    = 3'd1;
	localparam logic [2:0] REG_TEMP_OUT_SCALE = 3'd2;
	localparam logic [2:0] REG_SETPOINT_TEMP  = 3'd3;
	localparam logic [2:0] REG_DUTY_GAIN      = 3'd4;
	localparam logic [2:0] REG_DUTY_ENABLE    = 3'd5;

	localparam logic [15:0] RTD_DIVISOR_RST    = 16'd256;
	localparam logic [15:0] BAT_DIVISOR_RST    = 16'd256;
	localparam logic [15:0] TEMP_OUT_SCALE_RST = 16'd256;

	// shared divider: 32-bit dividend, 16-bit divisor, two quotient bits a cycle
	localparam int DIV_W     = 32;
	localparam int DVS_W     = 16;
	localparam int DIV_RADIX = 2;
	localparam int DIV_STEPS = DIV_W / DIV_RADIX;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int TABLE_ENTRIES_DEF = 20;
	localparam int TIDX_W            = 6;
	localparam int CODE_W            = 13;
	localparam int TEMP_W            = 16;
	localparam int TBL_N             = 20;
	localparam int TBL_IW            = $clog2(TBL_N);

	localparam logic [CODE_W-1:0] TBL_CODE [TBL_N] = '{
		13'd0, 13'd347, 13'd678, 13'd948, 13'd1173, 13'd1365, 13'd1531, 13'd1676,
		13'd1803, 13'd1916, 13'd2017, 13'd2107, 13'd2189, 13'd2263, 13'd2330,
		13'd2392, 13'd2448, 13'd2500, 13'd2809, 13'd4096
	};

	localparam logic signed [TEMP_W-1:0] TBL_TEMP [TBL_N] = '{
		-16'sd242, -16'sd200, -16'sd150, -16'sd100, -16'sd50, 16'sd0, 16'sd50,
		16'sd100, 16'sd150, 16'sd200, 16'sd250, 16'sd300, 16'sd350, 16'sd400,
		16'sd450, 16'sd500, 16'sd550, 16'sd600, 16'sd999, 16'sh7fff
	};

	typedef struct packed {
		logic [15:0] rtd_divisor;
		logic [15:0] bat_divisor;
		logic [15:0] temp_out_scale;
		logic [23:0] setpoint_temp;
		logic [15:0] duty_gain;
		logic        duty_enable;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	// entries past the built-in table repeat the last one
	function automatic logic [CODE_W-1:0] tbl_code(input logic [TIDX_W-1:0] idx);
		if (idx < TIDX_W'(TBL_N)) begin
			return TBL_CODE[idx[TBL_IW-1:0]];
		end
		return TBL_CODE[TBL_N-1];
	endfunction

	function automatic logic signed [TEMP_W-1:0] tbl_temp(input logic [TIDX_W-1:0] idx);
		if (idx < TIDX_W'(TBL_N)) begin
			return TBL_TEMP[idx[TBL_IW-1:0]];
		end
		return TBL_TEMP[TBL_N-1];
	endfunction

endpackage

[rtl/core/rtc_cfg.sv]
module rtc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtc_pkg::PADDR_W-1:0] paddr,
	input  logic [rtc_pkg::PDATA_W-1:0] pwdata,
	output logic [rtc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output rtc_pkg::cfg_t               cfg
);

	rtc_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rtd_divisor    <= rtc_pkg::RTD_DIVISOR_RST;
			cfg_q.bat_divisor    <= rtc_pkg::BAT_DIVISOR_RST;
			cfg_q.temp_out_scale <= rtc_pkg::TEMP_OUT_SCALE_RST;
			cfg_q.setpoint_temp  <= '0;
			cfg_q.duty_gain      <= '0;
			cfg_q.duty_enable    <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				rtc_pkg::REG_RTD_DIVISOR:    cfg_q.rtd_divisor    <= pwdata[15:0];
				rtc_pkg::REG_BAT_DIVISOR:    cfg_q.bat_divisor    <= pwdata[15:0];
				rtc_pkg::REG_TEMP_OUT_SCALE: cfg_q.temp_out_scale <= pwdata[15:0];
				rtc_pkg::REG_SETPOINT_TEMP:  cfg_q.setpoint_temp  <= pwdata[23:0];
				rtc_pkg::REG_DUTY_GAIN:      cfg_q.duty_gain      <= pwdata[15:0];
				rtc_pkg::REG_DUTY_ENABLE:    cfg_q.duty_enable    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rtc_pkg::REG_RTD_DIVISOR:    prdata = {16'd0, cfg_q.rtd_divisor};
			rtc_pkg::REG_BAT_DIVISOR:    prdata = {16'd0, cfg_q.bat_divisor};
			rtc_pkg::REG_TEMP_OUT_SCALE: prdata = {16'd0, cfg_q.temp_out_scale};
			rtc_pkg::REG_SETPOINT_TEMP:  prdata = {8'd0, cfg_q.setpoint_temp};
			rtc_pkg::REG_DUTY_GAIN:      prdata = {16'd0, cfg_q.duty_gain};
			rtc_pkg::REG_DUTY_ENABLE:    prdata = {31'd0, cfg_q.duty_enable};
			default:                     prdata = '0;
		endcase
	end

endmodule

[rtl/core/rtc_div.sv]
module rtc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rtc_pkg::div_req_t req,
	output rtc_pkg::div_rsp_t rsp
);

	localparam int W  = rtc_pkg::DIV_W;
	localparam int DW = rtc_pkg::DVS_W;
	localparam int CW = rtc_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [W-1:0]  dq_q;
	logic [DW-1:0] rem_d;
	logic [W-1:0]  dq_d;

	// restoring steps; dq_q shifts dividend bits out and quotient bits in
	always_comb begin
		logic [DW:0]   r1;
		logic [DW-1:0] r;
		logic [W-1:0]  d;
		r = rem_q;
		d = dq_q;
		for (int i = 0; i < rtc_pkg::DIV_RADIX; i++) begin
			r1 = {r, d[W-1]};
			d  = {d[W-2:0], 1'b0};
			if (r1 >= {1'b0, dvs_q}) begin
				r1   = r1 - {1'b0, dvs_q};
				d[0] = 1'b1;
			end
			r = r1[DW-1:0];
		end
		rem_d = r;
		dq_d  = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(rtc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= dq_d;
			rem_q <= rem_d;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = dq_q;

endmodule

[rtl/core/rtd_count_to_temperature_pcontrol_top.sv]
// channel  direction  handshake            word
// in       sink       in_valid / in_stall   rtd_count, battery_count
// out      source     out_valid / out_stall rtd_level, battery_level, temperature, duty
// cfg      APB slave  psel/penable/pready   paddr[4:2] selects register, pwdata
//
// From acceptance to a valid result a word passes through the RTD and battery divides on the
// shared two-bit-per-cycle divider, a table search, the numerator product on the shared
// multiplier, the interpolation divide, the temperature and duty products, and hand-off.
// in_stall is high from acceptance until the result is handed to the output register.
// The output register holds a result under out_stall while the next word is taken.
// Reset returns the sequencer to idle and empties the output register.
module rtd_count_to_temperature_pcontrol_top #(
	parameter int TABLE_ENTRIES = rtc_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtc_pkg::PADDR_W-1:0] paddr,
	input  logic [rtc_pkg::PDATA_W-1:0] pwdata,
	output logic [rtc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [14:0]                 rtd_count,
	input  logic [14:0]                 battery_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [15:0]                 rtd_level,
	output logic [19:0]                 battery_level,
	output logic signed [23:0]          temperature,
	output logic signed [31:0]          duty
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int TW    = rtc_pkg::TIDX_W;
	localparam int IW    = 21;

	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_DIV_RTD   = 11'b00000000010,
		S_DIV_BAT   = 11'b00000000100,
		S_SEARCH    = 11'b00000001000,
		S_MUL_NUM   = 11'b00000010000,
		S_NUM_ISSUE = 11'b00000100000,
		S_DIV_NUM   = 11'b00001000000,
		S_MUL_TEMP  = 11'b00010000000,
		S_TEMP      = 11'b00100000000,
		S_MUL_DUTY  = 11'b01000000000,
		S_DONE      = 11'b10000000000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	rtc_pkg::cfg_t     cfg;
	rtc_pkg::div_req_t div_req;
	rtc_pkg::div_rsp_t div_rsp;

	logic                         rtd_zero_q;
	logic                         bat_zero_q;
	logic [14:0]                  bat_cnt_q;
	logic [15:0]                  rtd_lvl_q;
	logic [19:0]                  bat_lvl_q;
	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             idx_m1;
	logic signed [42:0]           mul_q;
	logic signed [24:0]           mul_a;
	logic signed [17:0]           mul_b;
	logic                         num_neg_q;
	logic signed [IW-1:0]         interp_q;
	logic signed [23:0]           temp_q;
	logic                         out_valid_q;
	logic [15:0]                  rtd_out_q;
	logic [19:0]                  bat_out_q;
	logic signed [23:0]           temp_out_q;
	logic signed [31:0]           duty_out_q;

	logic                         accept;
	logic                         out_free;
	logic [rtc_pkg::CODE_W-1:0]   code_r;
	logic [rtc_pkg::CODE_W-1:0]   code_p;
	logic signed [rtc_pkg::TEMP_W-1:0] tval_r;
	logic signed [rtc_pkg::TEMP_W-1:0] tval_p;
	logic signed [16:0]           t_diff;
	logic signed [17:0]           l_diff;
	logic signed [13:0]           den;
	logic                         search_more;
	logic [42:0]                  num_mag;
	logic signed [21:0]           q_signed;
	logic signed [21:0]           base;
	logic signed [21:0]           interp_d;
	logic signed [34:0]           sh;
	logic signed [23:0]           temp_sat;
	logic signed [31:0]           duty_sat;
	logic signed [24:0]           diff;
	logic [15:0]                  rtd_lvl_d;
	logic [19:0]                  bat_lvl_d;

	rtc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign idx_m1 = (idx_q == '0) ? '0 : idx_q - 1'b1;
	assign code_r = rtc_pkg::tbl_code(TW'(idx_q));
	assign code_p = rtc_pkg::tbl_code(TW'(idx_m1));
	assign tval_r = rtc_pkg::tbl_temp(TW'(idx_q));
	assign tval_p = rtc_pkg::tbl_temp(TW'(idx_m1));

	assign t_diff = {tval_r[15], tval_r} - {tval_p[15], tval_p};
	assign l_diff = $signed({2'b00, rtd_lvl_q}) - $signed({1'b0, code_p, 4'b0000});
	assign den    = $signed({1'b0, code_r}) - $signed({1'b0, code_p});
	assign search_more = (idx_q < IDX_W'(TABLE_ENTRIES - 1)) &&
		({1'b0, rtd_lvl_q} > {code_r, 4'b0000});

	assign num_mag  = mul_q[42] ? 43'(-mul_q) : mul_q;
	assign q_signed = num_neg_q ? -$signed({1'b0, div_rsp.quot[20:0]})
		: $signed({1'b0, div_rsp.quot[20:0]});
	assign base     = 22'({{2{tval_p[15]}}, tval_p, 4'b0000});
	assign interp_d = (idx_q == '0 || den <= 0) ? base : base + q_signed;

	assign sh   = mul_q[42:8];
	assign diff = {cfg.setpoint_temp[23], cfg.setpoint_temp} - {temp_q[23], temp_q};

	always_comb begin
		if (!sh[34] && (|sh[33:23])) begin
			temp_sat = 24'sh7fffff;
		end else if (sh[34] && !(&sh[33:23])) begin
			temp_sat = -24'sh800000;
		end else begin
			temp_sat = sh[23:0];
		end
		if (!sh[34] && (|sh[33:31])) begin
			duty_sat = 32'sh7fffffff;
		end else if (sh[34] && !(&sh[33:31])) begin
			duty_sat = -32'sh80000000;
		end else begin
			duty_sat = sh[31:0];
		end
	end

	// zero divisor yields an all-ones quotient; a zero count still gives zero
	assign rtd_lvl_d = rtd_zero_q ? '0 : ((|div_rsp.quot[31:16]) ? '1 : div_rsp.quot[15:0]);
	assign bat_lvl_d = bat_zero_q ? '0 : ((|div_rsp.quot[31:20]) ? '1 : div_rsp.quot[19:0]);

	always_comb begin
		state_d = state_q;
		div_req = '0;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					div_req.start    = 1'b1;
					div_req.dividend = {5'd0, rtd_count, 12'd0};
					div_req.divisor  = cfg.rtd_divisor;
					state_d          = S_DIV_RTD;
				end
			end
			S_DIV_RTD: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {5'd0, bat_cnt_q, 12'd0};
					div_req.divisor  = cfg.bat_divisor;
					state_d          = S_DIV_BAT;
				end
			end
			S_DIV_BAT: begin
				if (div_rsp.done) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (!search_more) begin
					state_d = S_MUL_NUM;
				end
			end
			S_MUL_NUM: begin
				mul_a   = {{8{t_diff[16]}}, t_diff};
				mul_b   = l_diff;
				state_d = S_NUM_ISSUE;
			end
			S_NUM_ISSUE: begin
				div_req.start    = 1'b1;
				div_req.dividend = num_mag[31:0];
				div_req.divisor  = {2'b00, den};
				state_d          = S_DIV_NUM;
			end
			S_DIV_NUM: begin
				if (div_rsp.done) begin
					state_d = S_MUL_TEMP;
				end
			end
			S_MUL_TEMP: begin
				mul_a   = {{4{interp_q[IW-1]}}, interp_q};
				mul_b   = $signed({2'b00, cfg.temp_out_scale});
				state_d = S_TEMP;
			end
			S_TEMP: begin
				state_d = S_MUL_DUTY;
			end
			S_MUL_DUTY: begin
				mul_a   = diff;
				mul_b   = $signed({2'b00, cfg.duty_gain});
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rtd_zero_q <= (rtd_count == '0);
			bat_zero_q <= (battery_count == '0);
			bat_cnt_q  <= battery_count;
		end
		if (state_q == S_DIV_RTD && div_rsp.done) begin
			rtd_lvl_q <= rtd_lvl_d;
		end
		if (state_q == S_DIV_BAT && div_rsp.done) begin
			bat_lvl_q <= bat_lvl_d;
			idx_q     <= '0;
		end
		if (state_q == S_SEARCH && search_more) begin
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == S_MUL_NUM || state_q == S_MUL_TEMP || state_q == S_MUL_DUTY) begin
			mul_q <= mul_a * mul_b;
		end
		if (state_q == S_NUM_ISSUE) begin
			num_neg_q <= mul_q[42];
		end
		if (state_q == S_DIV_NUM && div_rsp.done) begin
			interp_q <= interp_d[IW-1:0];
		end
		if (state_q == S_TEMP) begin
			temp_q <= temp_sat;
		end
		if (state_q == S_DONE && out_free) begin
			rtd_out_q  <= rtd_lvl_q;
			bat_out_q  <= bat_lvl_q;
			temp_out_q <= temp_q;
			duty_out_q <= cfg.duty_enable ? duty_sat : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign rtd_level     = rtd_out_q;
	assign battery_level = bat_out_q;
	assign temperature   = temp_out_q;
	assign duty          = duty_out_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_RTD || state_q == S_DIV_BAT ||
			state_q == S_DIV_NUM))
		else $error("divider result outside a divide state");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH || state_q == S_MUL_NUM) |->
			idx_q <= IDX_W'(TABLE_ENTRIES - 1))
		else $error("table index past last entry");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DIV_RTD && div_rsp.busy))
		else $error("accepted word did not start the divider");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(duty_out_q)))
		else $error("stalled result changed");

endmodule
